// File: src/wtrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtrs_pkg
// Shared types and constants of the wrap tile rectangle splitter.
// ----------------------------------------------------------------------------
package wtrs_pkg;

    localparam int SCREEN_WIDTH_DEF  = 800;
    localparam int SCREEN_HEIGHT_DEF = 480;

    // sizes, positions and moduli all fit 13 bits (up to 4096)
    localparam int SIZE_W   = 13;
    localparam int REM_W    = 12;
    localparam int OFFS_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] BG_WIDTH_MIN  = 13'd128;
    localparam logic [SIZE_W-1:0] BG_HEIGHT_MIN = 13'd80;
    localparam logic [SIZE_W-1:0] BG_SIZE_MAX   = 13'd4096;
    localparam logic [SIZE_W-1:0] BG_WIDTH_RST  = 13'd800;
    localparam logic [SIZE_W-1:0] BG_HEIGHT_RST = 13'd480;

    localparam int MAX_RECTS = 56;
    localparam int CNT_W     = $clog2(MAX_RECTS);

    localparam logic [CFG_IDX_W-1:0] REG_BG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [OFFS_W-1:0] x_offset;
        logic signed [OFFS_W-1:0] y_offset;
    } offs_t;

    typedef struct packed {
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [9:0]  dst_x;
        logic [8:0]  dst_y;
        logic [9:0]  rect_width;
        logic [8:0]  rect_height;
        logic        last;
    } rect_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_stat_t;

endpackage
`default_nettype wire

// File: src/wtrs_mod_serial.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtrs_mod_serial
// Bit-serial signed modulo: one offset bit per cycle, msb first, remainder
// kept below the modulus by one compare and subtract.
// ----------------------------------------------------------------------------
module wtrs_mod_serial (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [wtrs_pkg::OFFS_W-1:0]   value,
    input  wire logic [wtrs_pkg::SIZE_W-1:0]   modulus,
    output logic      [wtrs_pkg::REM_W-1:0]    result,
    output wtrs_pkg::mod_stat_t                stat
);
    import wtrs_pkg::*;

    localparam int STEPS = OFFS_W - 1;
    localparam int STEP_W = $clog2(STEPS);

    logic [OFFS_W-2:0] shift_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [STEP_W-1:0] count_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SIZE_W-1:0] trial;
    logic [REM_W-1:0]  rem_next;
    logic [SIZE_W-1:0] mod_less_one;

    always_comb
    begin
        trial = {rem_reg, shift_reg[OFFS_W-2]};
        if (trial >= modulus)
        begin
            rem_next = REM_W'(trial - modulus);
        end
        else
        begin
            rem_next = REM_W'(trial);
        end
        mod_less_one = modulus - SIZE_W'(1);
    end

    // the sign bit carries weight -2^31: it starts the remainder at -1 mod m
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (count_reg == '0);
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= STEP_W'(STEPS - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - STEP_W'(1);
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= value[OFFS_W-2:0];
            rem_reg   <= value[OFFS_W-1] ? REM_W'(mod_less_one) : '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[OFFS_W-3:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign result    = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, rem_reg} < modulus))
        else $error("remainder not below modulus");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a reduction in flight");

endmodule
`default_nettype wire

// File: src/wtrs_rect_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtrs_rect_gen
// Rectangle sequencer: walks the screen band by band, left to right, one
// copy rectangle per cycle into an output register while not stalled.
// ----------------------------------------------------------------------------
module wtrs_rect_gen #(
    parameter int SCREEN_WIDTH  = wtrs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = wtrs_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [wtrs_pkg::REM_W-1:0]  x_wrap,
    input  wire logic [wtrs_pkg::REM_W-1:0]  y_wrap,
    input  wire logic [wtrs_pkg::SIZE_W-1:0] bg_w,
    input  wire logic [wtrs_pkg::SIZE_W-1:0] bg_h,
    output logic                             rect_valid,
    input  wire logic                        rect_ready,
    output wtrs_pkg::rect_t                  rect,
    output logic                             done
);
    import wtrs_pkg::*;

    localparam logic [SIZE_W-1:0] SW = SIZE_W'(SCREEN_WIDTH);
    localparam logic [SIZE_W-1:0] SH = SIZE_W'(SCREEN_HEIGHT);

    logic              active_reg;
    logic              done_reg;
    logic              out_valid_reg;
    rect_t             out_reg;
    logic [REM_W-1:0]  xo_reg;
    logic [REM_W-1:0]  sx_reg;
    logic [REM_W-1:0]  sy_reg;
    logic [SIZE_W-1:0] dx_reg;
    logic [SIZE_W-1:0] dy_reg;
    logic [CNT_W-1:0]  n_reg;

    logic [SIZE_W-1:0] rem_w;
    logic [SIZE_W-1:0] scr_w;
    logic [SIZE_W-1:0] rem_h;
    logic [SIZE_W-1:0] scr_h;
    logic [SIZE_W-1:0] ww;
    logic [SIZE_W-1:0] hh;
    logic              row_end;
    logic              col_end;
    logic              last;
    logic              load;

    always_comb
    begin
        rem_w   = bg_w - {1'b0, sx_reg};
        scr_w   = SW - dx_reg;
        rem_h   = bg_h - {1'b0, sy_reg};
        scr_h   = SH - dy_reg;
        row_end = (scr_w <= rem_w);
        col_end = (scr_h <= rem_h);
        ww      = row_end ? scr_w : rem_w;
        hh      = col_end ? scr_h : rem_h;
        last    = (row_end && col_end) || (n_reg == CNT_W'(MAX_RECTS - 1));
        load    = active_reg && (!out_valid_reg || rect_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
        end
        else
        begin
            done_reg <= load && last && !start;
            if (start)
            begin
                active_reg <= 1'b1;
                n_reg      <= '0;
                if (rect_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (load)
            begin
                out_valid_reg <= 1'b1;
                n_reg         <= n_reg + CNT_W'(1);
                if (last)
                begin
                    active_reg <= 1'b0;
                end
            end
            else if (rect_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // only the first rectangle of a band, or of the first band, starts inside the image
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xo_reg <= x_wrap;
            sx_reg <= x_wrap;
            sy_reg <= y_wrap;
            dx_reg <= '0;
            dy_reg <= '0;
        end
        else if (load)
        begin
            out_reg.src_x       <= sx_reg;
            out_reg.src_y       <= sy_reg;
            out_reg.dst_x       <= dx_reg[9:0];
            out_reg.dst_y       <= dy_reg[8:0];
            out_reg.rect_width  <= ww[9:0];
            out_reg.rect_height <= hh[8:0];
            out_reg.last        <= last;
            if (row_end)
            begin
                sx_reg <= xo_reg;
                dx_reg <= '0;
                sy_reg <= '0;
                dy_reg <= dy_reg + hh;
            end
            else
            begin
                sx_reg <= '0;
                dx_reg <= dx_reg + ww;
            end
        end
    end

    assign rect_valid = out_valid_reg;
    assign rect       = out_reg;
    assign done       = done_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (n_reg < CNT_W'(MAX_RECTS)))
        else $error("rectangle count past cap");

    a_inside_screen: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> ((dx_reg < SW) && (dy_reg < SH)))
        else $error("walk position left the screen");

    a_keeps_going: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !last && !start) |=> active_reg)
        else $error("walk stopped before last rectangle");

endmodule
`default_nettype wire

// File: src/wrap_tile_rect_splitter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrap_tile_rect_splitter_unit
// Wraps a signed scroll offset pair into the background and tiles the
// screen with copy rectangles.
// ----------------------------------------------------------------------------
//  channel  signals                                word      dir
//  offs     offs_valid / offs_ready / offs         offs_t    in
//  rect     rect_valid / rect_ready / rect         rect_t    out
//  cfg      cfg_valid / cfg_ready / cfg_index,data 13 bits   in
//
//  each offset word goes through bit-serial modulo reduction (x and y
//  in parallel, sign at accept, then one offset bit per cycle), then one
//  rectangle per cycle while the rect channel does not stall, up to 56,
//  before the next offset word can be accepted.
//  reset loads bg_width 800 and bg_height 480.
//  a stalled rect channel holds the sequencer; after the last rectangle is
//  loaded, its done register and then the state register raise offs_ready.
// ----------------------------------------------------------------------------
module wrap_tile_rect_splitter_unit #(
    parameter int SCREEN_WIDTH  = wtrs_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = wtrs_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           offs_valid,
    output logic                                offs_ready,
    input  wire wtrs_pkg::offs_t                offs,
    output logic                                rect_valid,
    input  wire logic                           rect_ready,
    output wtrs_pkg::rect_t                     rect,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wtrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wtrs_pkg::SIZE_W-1:0]    cfg_data
);
    import wtrs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SIZE_W-1:0] bg_width_reg;
    logic [SIZE_W-1:0] bg_height_reg;
    logic [SIZE_W-1:0] bw;
    logic [SIZE_W-1:0] bh;
    logic [REM_W-1:0]  x_wrap;
    logic [REM_W-1:0]  y_wrap;
    mod_stat_t         x_stat;
    mod_stat_t         y_stat;
    logic              accept;
    logic              gen_start;
    logic              gen_done;

    always_comb
    begin
        priority if (bg_width_reg < BG_WIDTH_MIN)
            bw = BG_WIDTH_MIN;
        else if (bg_width_reg > BG_SIZE_MAX)
            bw = BG_SIZE_MAX;
        else
            bw = bg_width_reg;
        priority if (bg_height_reg < BG_HEIGHT_MIN)
            bh = BG_HEIGHT_MIN;
        else if (bg_height_reg > BG_SIZE_MAX)
            bh = BG_SIZE_MAX;
        else
            bh = bg_height_reg;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_width_reg  <= BG_WIDTH_RST;
            bg_height_reg <= BG_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_BG_WIDTH)
            begin
                bg_width_reg <= cfg_data;
            end
            else if (cfg_index == REG_BG_HEIGHT)
            begin
                bg_height_reg <= cfg_data;
            end
        end
    end

    assign offs_ready = (state_reg == ST_IDLE);
    assign accept     = offs_valid && offs_ready;
    // both reductions run the same number of steps
    assign gen_start  = (state_reg == ST_REDUCE) && x_stat.done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (x_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (gen_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    wtrs_mod_serial u_mod_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .value   (offs.x_offset),
        .modulus (bw),
        .result  (x_wrap),
        .stat    (x_stat)
    );

    wtrs_mod_serial u_mod_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .value   (offs.y_offset),
        .modulus (bh),
        .result  (y_wrap),
        .stat    (y_stat)
    );

    wtrs_rect_gen #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_rect_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (gen_start),
        .x_wrap     (x_wrap),
        .y_wrap     (y_wrap),
        .bg_w       (bw),
        .bg_h       (bh),
        .rect_valid (rect_valid),
        .rect_ready (rect_ready),
        .rect       (rect),
        .done       (gen_done)
    );

    a_mods_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (x_stat.busy == y_stat.busy) && (x_stat.done == y_stat.done))
        else $error("x and y reductions out of step");

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the wrap tile rectangle splitter against a behavioral tiling model.
// Directed offset words cover the extreme offsets, the smallest and largest
// backgrounds, size clamping and writes to unused register indexes. Random
// phases then reprogram the sizes and stream offset words in bursts while
// the rectangle side stalls in several patterns. Every rectangle is compared
// field by field with the predicted tiling, in order.
// ----------------------------------------------------------------------------
module testbench;
    import wtrs_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PAD       = 8;
    localparam int END_PAD        = 80;
    localparam int MAX_SHOWN      = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 25;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_LONG
    } stall_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 offs_valid;
    logic                 offs_ready;
    offs_t                offs;
    logic                 rect_valid;
    logic                 rect_ready;
    rect_t                rect;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    // copy of the size registers as the block should hold them
    logic [SIZE_W-1:0] bg_width_reg;
    logic [SIZE_W-1:0] bg_height_reg;

    rect_t       pending_rects[$];
    int          errors;
    int          words_sent;
    int          rects_checked;
    int          cfg_writes;
    int          most_rects;
    int          idle_cycles;
    stall_mode_t stall_mode;
    logic [15:0] ready_pat;
    logic [3:0]  pat_pos;
    int          long_hold;

    wrap_tile_rect_splitter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .offs_valid (offs_valid),
        .offs_ready (offs_ready),
        .offs       (offs),
        .rect_valid (rect_valid),
        .rect_ready (rect_ready),
        .rect       (rect),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    function automatic int unsigned bg_size(input logic [SIZE_W-1:0] value,
                                            input logic [SIZE_W-1:0] lowest);
        if (value < lowest)
            return lowest;
        if (value > BG_SIZE_MAX)
            return BG_SIZE_MAX;
        return value;
    endfunction

    // wrap the offsets and cover the screen band by band, left to right
    function automatic void tile_screen(input logic signed [OFFS_W-1:0] x_off,
                                        input logic signed [OFFS_W-1:0] y_off);
        int unsigned bw;
        int unsigned bh;
        int unsigned x_rem;
        int unsigned y_rem;
        int unsigned sx;
        int unsigned sy;
        int unsigned dx;
        int unsigned dy;
        int unsigned ww;
        int unsigned hh;
        longint      rem;
        rect_t       tile;
        rect_t       tiles[$];

        bw = bg_size(bg_width_reg, BG_WIDTH_MIN);
        bh = bg_size(bg_height_reg, BG_HEIGHT_MIN);
        rem = longint'(x_off) % longint'(bw);
        if (rem < 0)
            rem = rem + longint'(bw);
        x_rem = 32'(rem);
        rem = longint'(y_off) % longint'(bh);
        if (rem < 0)
            rem = rem + longint'(bh);
        y_rem = 32'(rem);

        dy = 0;
        while (dy < SCREEN_HEIGHT_DEF && tiles.size() < MAX_RECTS)
        begin
            sy = (y_rem + dy) % bh;
            hh = bh - sy;
            if (hh > SCREEN_HEIGHT_DEF - dy)
                hh = SCREEN_HEIGHT_DEF - dy;
            dx = 0;
            while (dx < SCREEN_WIDTH_DEF && tiles.size() < MAX_RECTS)
            begin
                sx = (x_rem + dx) % bw;
                ww = bw - sx;
                if (ww > SCREEN_WIDTH_DEF - dx)
                    ww = SCREEN_WIDTH_DEF - dx;
                tile.src_x       = 12'(sx);
                tile.src_y       = 12'(sy);
                tile.dst_x       = 10'(dx);
                tile.dst_y       = 9'(dy);
                tile.rect_width  = 10'(ww);
                tile.rect_height = 9'(hh);
                tile.last        = 1'b0;
                tiles.push_back(tile);
                dx = dx + ww;
            end
            dy = dy + hh;
        end

        tile = tiles.pop_back();
        tile.last = 1'b1;
        tiles.push_back(tile);
        foreach (tiles[i])
            pending_rects.push_back(tiles[i]);
        if (tiles.size() > most_rects)
            most_rects = tiles.size();
    endfunction

    // predicts on accepted offset words, tracks register writes, checks rectangles
    always @(posedge clk)
    begin : rect_monitor
        rect_t want;

        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                if (cfg_index == REG_BG_WIDTH)
                    bg_width_reg = cfg_data;
                else if (cfg_index == REG_BG_HEIGHT)
                    bg_height_reg = cfg_data;
            end
            if (offs_valid && offs_ready)
                tile_screen(offs.x_offset, offs.y_offset);
            if (rect_valid && rect_ready)
            begin
                if (pending_rects.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("%0t: unexpected rectangle src (%0d,%0d) dst (%0d,%0d)",
                                 $realtime, rect.src_x, rect.src_y, rect.dst_x, rect.dst_y);
                end
                else
                begin
                    want = pending_rects.pop_front();
                    rects_checked++;
                    if (rect.src_x !== want.src_x || rect.src_y !== want.src_y ||
                        rect.dst_x !== want.dst_x || rect.dst_y !== want.dst_y ||
                        rect.rect_width !== want.rect_width ||
                        rect.rect_height !== want.rect_height ||
                        rect.last !== want.last)
                    begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                        begin
                            $display("%0t: expected src (%0d,%0d) dst (%0d,%0d) %0dx%0d last %0b",
                                     $realtime, want.src_x, want.src_y, want.dst_x,
                                     want.dst_y, want.rect_width, want.rect_height, want.last);
                            $display("%0t:      got src (%0d,%0d) dst (%0d,%0d) %0dx%0d last %0b",
                                     $realtime, rect.src_x, rect.src_y, rect.dst_x,
                                     rect.dst_y, rect.rect_width, rect.rect_height, rect.last);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((offs_valid && offs_ready) || (rect_valid && rect_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d rectangles outstanding",
                     idle_cycles, pending_rects.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // rectangle side back-pressure
    always @(negedge clk)
    begin
        case (stall_mode)
            STALL_NONE:
                rect_ready <= 1'b1;
            STALL_RANDOM:
                rect_ready <= ($urandom_range(9) > 2);
            STALL_PATTERN:
            begin
                rect_ready <= ready_pat[pat_pos];
                pat_pos    <= pat_pos + 4'd1;
            end
            default:
            begin
                if (long_hold != 0)
                begin
                    rect_ready <= 1'b0;
                    long_hold  <= long_hold - 1;
                end
                else
                begin
                    rect_ready <= 1'b1;
                    if ($urandom_range(19) == 0)
                        long_hold <= $urandom_range(30, 4);
                end
            end
        endcase
    end

    task automatic set_stall(input stall_mode_t mode);
        @(posedge clk);
        stall_mode = mode;
        ready_pat  = 16'($urandom) | 16'h0101;
    endtask

    task automatic send_offs(input logic signed [OFFS_W-1:0] x_off,
                             input logic signed [OFFS_W-1:0] y_off);
        @(negedge clk);
        offs_valid <= 1'b1;
        offs       <= {x_off, y_off};
        do
            @(posedge clk);
        while (!offs_ready);
        words_sent++;
    endtask

    task automatic offs_gap(input int cycles);
        @(negedge clk);
        offs_valid <= 1'b0;
        offs       <= {32'($urandom), 32'($urandom)};
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_all_rects();
        @(negedge clk);
        offs_valid <= 1'b0;
        while (pending_rects.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [OFFS_W-1:0] rand_offset(input int unsigned size);
        logic signed [OFFS_W-1:0] v;

        case ($urandom_range(5))
            0, 1:
                v = $urandom;
            2:
                v = $urandom_range(2 * size);
            3:
                v = -$urandom_range(2 * size);
            4:
            begin
                // just around a multiple of the background size
                v = $urandom_range(400000) * size + $urandom_range(2) - 1;
                if ($urandom_range(1))
                    v = -v;
            end
            default:
            begin
                case ($urandom_range(3))
                    0: v = 32'sh7FFFFFFF;
                    1: v = 32'sh80000000;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size(input logic [SIZE_W-1:0] lowest);
        case ($urandom_range(9))
            0: return lowest;
            1: return BG_SIZE_MAX;
            2, 3: return SIZE_W'($urandom);
            default: return SIZE_W'($urandom_range(BG_SIZE_MAX, lowest));
        endcase
    endfunction

    task automatic test_default_size();
        set_stall(STALL_NONE);
        send_offs(0, 0);
        send_offs(-1, -1);
        send_offs(32'sh7FFFFFFF, 32'sh80000000);
        send_offs(32'sh80000000, 32'sh7FFFFFFF);
        send_offs(799, 479);
        send_offs(800, 480);
        send_offs(400, 240);
    endtask

    // 128 x 80 with both offsets near the top of the range gives 56 rectangles
    task automatic test_smallest_background();
        wait_all_rects();
        write_reg(REG_BG_WIDTH, BG_WIDTH_MIN);
        write_reg(REG_BG_HEIGHT, BG_HEIGHT_MIN);
        set_stall(STALL_RANDOM);
        send_offs(127, 79);
        send_offs(97, 1);
        send_offs(96, 0);
        send_offs(-129, -81);
    endtask

    task automatic test_largest_background();
        wait_all_rects();
        write_reg(REG_BG_WIDTH, BG_SIZE_MAX);
        write_reg(REG_BG_HEIGHT, BG_SIZE_MAX);
        set_stall(STALL_PATTERN);
        send_offs(0, 0);
        send_offs(4095, 4095);
        send_offs(3500, 3800);
        send_offs(32'sh80000000, 32'sh80000000);
    endtask

    task automatic test_size_clamping();
        set_stall(STALL_LONG);
        wait_all_rects();
        write_reg(REG_BG_WIDTH, '0);
        write_reg(REG_BG_HEIGHT, '0);
        send_offs(127, 79);
        wait_all_rects();
        write_reg(REG_BG_WIDTH, '1);
        write_reg(REG_BG_HEIGHT, '1);
        send_offs(4000, 3900);
        wait_all_rects();
        write_reg(REG_BG_WIDTH, BG_WIDTH_MIN - SIZE_W'(1));
        write_reg(REG_BG_HEIGHT, BG_HEIGHT_MIN - SIZE_W'(1));
        send_offs(-1, -1);
        wait_all_rects();
        write_reg(REG_BG_WIDTH, BG_SIZE_MAX + SIZE_W'(1));
        write_reg(REG_BG_HEIGHT, BG_SIZE_MAX + SIZE_W'(1));
        send_offs(4095, 4095);
    endtask

    task automatic test_spare_index();
        set_stall(STALL_NONE);
        wait_all_rects();
        write_reg(REG_BG_WIDTH, 13'd200);
        write_reg(REG_BG_HEIGHT, 13'd100);
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '0);
        send_offs(150, 90);
        send_offs(-1, 99);
    endtask

    task automatic test_random_traffic();
        int  sent;
        int  burst;
        bit  no_gaps;

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_all_rects();
            if ($urandom_range(1))
            begin
                write_reg(REG_BG_WIDTH, rand_size(BG_WIDTH_MIN));
                write_reg(REG_BG_HEIGHT, rand_size(BG_HEIGHT_MIN));
            end
            else
            begin
                write_reg(REG_BG_HEIGHT, rand_size(BG_HEIGHT_MIN));
                write_reg(REG_BG_WIDTH, rand_size(BG_WIDTH_MIN));
            end
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, SIZE_W'($urandom));
            set_stall(stall_mode_t'($urandom_range(3)));
            no_gaps = ($urandom_range(3) == 0);

            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                burst = $urandom_range(8, 1);
                for (int i = 0; i < burst && sent < PHASE_WORDS; i++)
                begin
                    send_offs(rand_offset(bg_size(bg_width_reg, BG_WIDTH_MIN)),
                              rand_offset(bg_size(bg_height_reg, BG_HEIGHT_MIN)));
                    sent++;
                end
                if ($urandom_range(15) == 0)
                    wait_all_rects();
                else if (!no_gaps && $urandom_range(3) != 0)
                    offs_gap($urandom_range(12, 1));
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        offs_valid    = 1'b0;
        offs          = '0;
        rect_ready    = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_BG_WIDTH;
        cfg_data      = '0;
        stall_mode    = STALL_NONE;
        ready_pat     = 16'hFFFF;
        pat_pos       = '0;
        long_hold     = 0;
        bg_width_reg  = BG_WIDTH_RST;
        bg_height_reg = BG_HEIGHT_RST;
        errors        = 0;
        words_sent    = 0;
        rects_checked = 0;
        cfg_writes    = 0;
        most_rects    = 0;
        idle_cycles   = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_size();
        test_smallest_background();
        test_largest_background();
        test_size_clamping();
        test_spare_index();
        test_random_traffic();

        wait_all_rects();
        repeat (END_PAD) @(posedge clk);
        if (pending_rects.size() != 0)
        begin
            $display("%0d rectangles never arrived", pending_rects.size());
            errors = errors + pending_rects.size();
        end

        $display("ran %0d offset words and %0d register writes, %0d rectangles compared",
                 words_sent, cfg_writes, rects_checked);
        $display("largest tiling was %0d rectangles, %0d failures", most_rects, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
